/* src/grc_pkg.sv */
// Shared types and constants for the reachability closure engine.
package grc_pkg;

    // Fixed field widths
    localparam int NODE_W = 5;
    localparam int VCNT_W = 6;
    // Effective vertex count fits one bit above the register (up to 64)
    localparam int EFF_W  = 7;

    // Item kinds
    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic reachable;
        logic out_of_range;
    } t_out_item;

    // Row unit operations
    typedef enum logic [1:0] {
        ALU_PASS,
        ALU_SET,
        ALU_MERGE
    } t_alu_op;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_E_RDA,
        ST_E_WRA,
        ST_E_RDB,
        ST_E_WRB,
        ST_C_PRD,
        ST_C_PLD,
        ST_C_RRD,
        ST_C_RWR,
        ST_Q_RD,
        ST_Q_OUT
    } t_state;

endpackage

/* src/grc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/grc_row_alu.sv */
// Shared row unit: identity fixup of unwritten rows, bit set, pivot merge, bit test.
module grc_row_alu #(
    parameter int MAX_VERTICES = 32
) (
    input  grc_pkg::t_alu_op                   i_op,
    input  logic [MAX_VERTICES-1:0]            i_row,
    input  logic                               i_row_ok,
    input  logic [$clog2(MAX_VERTICES)-1:0]    i_row_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0]    i_idx,
    input  logic [MAX_VERTICES-1:0]            i_pivot_row,
    output logic [MAX_VERTICES-1:0]            o_row,
    output logic                               o_hit
);

    logic [MAX_VERTICES-1:0] fixed_row;

    // A row never written is read as its reset value: the diagonal bit only
    assign fixed_row = i_row_ok ? i_row : (MAX_VERTICES'(1) << i_row_addr);
    assign o_hit     = fixed_row[i_idx];

    always_comb begin
        case (i_op)
            grc_pkg::ALU_SET:   o_row = fixed_row | (MAX_VERTICES'(1) << i_idx);
            grc_pkg::ALU_MERGE: o_row = fixed_row | i_pivot_row;
            default:            o_row = fixed_row;
        endcase
    end

endmodule

/* src/graph_reachability_closure.sv */
// Top level: undirected reachability engine with in-place Warshall closure.
//
// Input channel (i_in_valid / o_in_stall, payload i_in) takes edge and query
// beats; a beat is taken when valid is high and stall is low. Results leave on
// o_out_valid / i_out_stall with payload o_out, one per query, none per edge.
// The vertex count register is written over i_cfg_valid / o_cfg_ready / i_cfg_data.
// Work per item, with all rows held in one RAM with one read and one write port:
//   edge in range      : read-modify-write of both rows
//   edge out of range  : dropped on acceptance
//   query, out of range: result loaded without a row read
//   query, closure good: read of row a, then the result
//   query, closure stale: closure over the effective count n first;
//     each pivot costs one row read plus a read and a conditional write per row.
// One item is in work at a time; stall stays high until it is finished.
// A result waiting on a stalled receiver does not block edge beats, but the
// next query holds in its last cycle until the output register frees up.
// Reset (synchronous, active low) restores the identity matrix through per-row
// valid bits, marks the closure stale and sets the vertex count to 32.
module graph_reachability_closure #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  grc_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output grc_pkg::t_out_item                  o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [grc_pkg::VCNT_W-1:0]          i_cfg_data
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int EW = grc_pkg::EFF_W;
    localparam logic [EW-1:0] MV_E = EW'(MAX_VERTICES);

    // State
    grc_pkg::t_state              r_state, n_state;
    logic [grc_pkg::VCNT_W-1:0]   r_vcount;
    logic                         r_closed;
    logic [MAX_VERTICES-1:0]      r_row_ok;
    logic [AW-1:0]                r_a, r_b;
    logic                         r_oor;
    logic [AW-1:0]                r_piv, n_piv;
    logic [AW-1:0]                r_row, n_row;
    logic [AW-1:0]                r_rd_addr;
    logic [MAX_VERTICES-1:0]      r_piv_row;
    logic                         r_out_valid;
    grc_pkg::t_out_item           r_out;

    // Control strobes
    logic                         in_fire, cfg_fire;
    logic                         rd_en, wr_en;
    logic [AW-1:0]                rd_addr, wr_addr;
    logic                         out_load, piv_load, set_closed;
    grc_pkg::t_alu_op             alu_op;
    logic [AW-1:0]                alu_idx;
    logic [MAX_VERTICES-1:0]      alu_row;
    logic                         alu_hit;
    logic [MAX_VERTICES-1:0]      ram_rd_data;

    // Effective count and range check on incoming vertices
    logic [EW-1:0] vc_ext, eff;
    logic [EW-1:0] a_ext, b_ext;
    logic          in_range, row_last, piv_last, out_free;

    assign vc_ext   = EW'(r_vcount);
    assign eff      = (vc_ext > MV_E) ? MV_E : vc_ext;
    assign a_ext    = EW'(i_in.node_a);
    assign b_ext    = EW'(i_in.node_b);
    assign in_range = (a_ext < eff) && (b_ext < eff);
    assign row_last = (EW'(r_row) + EW'(1)) == eff;
    assign piv_last = (EW'(r_piv) + EW'(1)) == eff;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != grc_pkg::ST_IDLE);
    assign o_cfg_ready = (r_state == grc_pkg::ST_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Row storage
    grc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (alu_row),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    grc_row_alu #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_alu (
        .i_op        (alu_op),
        .i_row       (ram_rd_data),
        .i_row_ok    (r_row_ok[r_rd_addr]),
        .i_row_addr  (r_rd_addr),
        .i_idx       (alu_idx),
        .i_pivot_row (r_piv_row),
        .o_row       (alu_row),
        .o_hit       (alu_hit)
    );

    // Sequencer: next state and strobes
    always_comb begin
        n_state    = r_state;
        n_piv      = r_piv;
        n_row      = r_row;
        rd_en      = 1'b0;
        rd_addr    = r_a;
        wr_en      = 1'b0;
        wr_addr    = r_a;
        alu_op     = grc_pkg::ALU_PASS;
        alu_idx    = r_b;
        out_load   = 1'b0;
        piv_load   = 1'b0;
        set_closed = 1'b0;
        case (r_state)
            grc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.kind == grc_pkg::KIND_EDGE) begin
                        if (in_range) begin
                            n_state = grc_pkg::ST_E_RDA;
                        end
                    end else if (!in_range) begin
                        n_state = grc_pkg::ST_Q_OUT;
                    end else if (r_closed) begin
                        n_state = grc_pkg::ST_Q_RD;
                    end else begin
                        n_piv   = '0;
                        n_state = grc_pkg::ST_C_PRD;
                    end
                end
            end
            // Edge: set bit b in row a, then bit a in row b
            grc_pkg::ST_E_RDA: begin
                rd_en   = 1'b1;
                rd_addr = r_a;
                n_state = grc_pkg::ST_E_WRA;
            end
            grc_pkg::ST_E_WRA: begin
                alu_op  = grc_pkg::ALU_SET;
                alu_idx = r_b;
                wr_en   = 1'b1;
                wr_addr = r_a;
                n_state = grc_pkg::ST_E_RDB;
            end
            grc_pkg::ST_E_RDB: begin
                rd_en   = 1'b1;
                rd_addr = r_b;
                n_state = grc_pkg::ST_E_WRB;
            end
            grc_pkg::ST_E_WRB: begin
                alu_op  = grc_pkg::ALU_SET;
                alu_idx = r_a;
                wr_en   = 1'b1;
                wr_addr = r_b;
                n_state = grc_pkg::ST_IDLE;
            end
            // Closure: fetch pivot row, then sweep the rows below the effective count
            grc_pkg::ST_C_PRD: begin
                rd_en   = 1'b1;
                rd_addr = r_piv;
                n_state = grc_pkg::ST_C_PLD;
            end
            grc_pkg::ST_C_PLD: begin
                alu_op   = grc_pkg::ALU_PASS;
                piv_load = 1'b1;
                n_row    = '0;
                n_state  = grc_pkg::ST_C_RRD;
            end
            grc_pkg::ST_C_RRD: begin
                rd_en   = 1'b1;
                rd_addr = r_row;
                n_state = grc_pkg::ST_C_RWR;
            end
            grc_pkg::ST_C_RWR: begin
                alu_op  = grc_pkg::ALU_MERGE;
                alu_idx = r_piv;
                wr_en   = alu_hit;
                wr_addr = r_row;
                if (!row_last) begin
                    n_row   = r_row + AW'(1);
                    n_state = grc_pkg::ST_C_RRD;
                end else if (!piv_last) begin
                    n_piv   = r_piv + AW'(1);
                    n_state = grc_pkg::ST_C_PRD;
                end else begin
                    set_closed = 1'b1;
                    n_state    = grc_pkg::ST_Q_RD;
                end
            end
            // Query: read row a, test bit b
            grc_pkg::ST_Q_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_a;
                n_state = grc_pkg::ST_Q_OUT;
            end
            grc_pkg::ST_Q_OUT: begin
                alu_op  = grc_pkg::ALU_PASS;
                alu_idx = r_b;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = grc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = grc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grc_pkg::ST_IDLE;
            r_vcount    <= grc_pkg::VCNT_W'(32);
            r_closed    <= 1'b0;
            r_row_ok    <= '0;
            r_out_valid <= 1'b0;
            r_piv       <= '0;
            r_row       <= '0;
        end else begin
            r_state <= n_state;
            r_piv   <= n_piv;
            r_row   <= n_row;
            if (cfg_fire) begin
                r_vcount <= i_cfg_data;
                r_closed <= 1'b0;
            end else if (in_fire && i_in.kind == grc_pkg::KIND_EDGE && in_range) begin
                r_closed <= 1'b0;
            end else if (set_closed) begin
                r_closed <= 1'b1;
            end
            if (wr_en) begin
                r_row_ok[wr_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a   <= a_ext[AW-1:0];
            r_b   <= b_ext[AW-1:0];
            r_oor <= !in_range;
        end
        if (rd_en) begin
            r_rd_addr <= rd_addr;
        end
        if (piv_load) begin
            r_piv_row <= alu_row;
        end
        if (out_load) begin
            r_out.reachable    <= !r_oor && alu_hit;
            r_out.out_of_range <= r_oor;
        end
    end

endmodule

/* tb/tb_graph_reachability_closure.sv */
// Self-checking testbench for the reachability closure engine.
`timescale 1ns / 100ps

module tb_graph_reachability_closure;

    localparam int MAXV        = 32;
    localparam int NODE_W      = grc_pkg::NODE_W;
    localparam int VCNT_W      = grc_pkg::VCNT_W;
    localparam int SETTLE      = 16;        // margin for trailing edge work to finish
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 20000000;
    localparam int DIR_N       = 27;

    // One row of the directed table: a count write or an item beat
    typedef struct packed {
        logic               is_cfg;
        logic [VCNT_W-1:0]  cfg_val;
        grc_pkg::t_in_item  item;
        logic               typed;
        grc_pkg::t_out_item want;
    } t_dir_row;

    // DUT ports; the driven inputs are known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    logic               o_in_stall;
    grc_pkg::t_in_item  in_data     = '0;
    logic               o_out_valid;
    logic               out_stall   = 1'b0;
    grc_pkg::t_out_item o_out;
    logic               cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [VCNT_W-1:0]  cfg_data    = '0;

    // Shadow of the block: matrix, closure flag, vertex count
    logic [MAXV-1:0]   reach_mat [MAXV];
    bit                closure_fresh;
    logic [VCNT_W-1:0] vcount_shadow;

    grc_pkg::t_out_item reach_expect_q [$];
    t_dir_row           dir_tab [DIR_N];
    logic [VCNT_W-1:0]  phase_counts [18] = '{6'd32, 6'd4, 6'd1, 6'd63, 6'd8, 6'd2,
                                              6'd33, 6'd12, 6'd0, 6'd6, 6'd20, 6'd3,
                                              6'd5, 6'd10, 6'd7, 6'd16, 6'd9, 6'd32};

    int  mismatch_cnt  = 0;
    int  results_seen  = 0;
    int  beats_in      = 0;
    int  count_writes  = 0;
    int  cycle_cnt     = 0;
    int  tx_idle_pct   = 36;
    int  rx_idle_pct   = 87;
    bit  hold_go       = 1'b0;
    bit  hold_done     = 1'b0;
    int  hold_left     = 0;

    graph_reachability_closure uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("graph_reachability_closure: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("ERROR cycle %0d: %s", cycle_cnt, what);
        mismatch_cnt++;
    endtask

    // Receiver stall: random, or one long hold when requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Result checker: each accepted beat against the oldest expectation
    always @(posedge i_clk) begin
        grc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (reach_expect_q.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = reach_expect_q.pop_front();
                if (o_out.reachable !== want.reachable)
                    report_mismatch($sformatf("reachable got %b want %b",
                                              o_out.reachable, want.reachable));
                if (o_out.out_of_range !== want.out_of_range)
                    report_mismatch($sformatf("out_of_range got %b want %b",
                                              o_out.out_of_range, want.out_of_range));
            end
        end
    end

    function automatic int eff_vertices();
        return (int'(vcount_shadow) > MAXV) ? MAXV : int'(vcount_shadow);
    endfunction

    // Predictor: in-range edge sets both bits, first in-range query after a change closes the matrix
    task automatic reach_predict(input grc_pkg::t_in_item it, output bit has_res,
                                 output grc_pkg::t_out_item res);
        int n;
        bit in_rng;
        n = eff_vertices();
        in_rng = (int'(it.node_a) < n) && (int'(it.node_b) < n);
        has_res = 1'b0;
        res = '0;
        if (it.kind == grc_pkg::KIND_EDGE) begin
            if (in_rng) begin
                reach_mat[it.node_a][it.node_b] = 1'b1;
                reach_mat[it.node_b][it.node_a] = 1'b1;
                closure_fresh = 1'b0;
            end
        end else begin
            has_res = 1'b1;
            if (!in_rng) begin
                res.out_of_range = 1'b1;
            end else begin
                if (!closure_fresh) begin
                    for (int p = 0; p < n; p++)
                        for (int r = 0; r < n; r++)
                            if (reach_mat[r][p])
                                reach_mat[r] = reach_mat[r] | reach_mat[p];
                    closure_fresh = 1'b1;
                end
                res.reachable = reach_mat[it.node_a][it.node_b];
            end
        end
    endtask

    // Offer one beat after a random gap, hold it until taken, then predict
    task automatic send_item(input grc_pkg::t_in_item it, input bit typed,
                             input grc_pkg::t_out_item want);
        bit has_res;
        grc_pkg::t_out_item res;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        beats_in++;
        reach_predict(it, has_res, res);
        if (has_res)
            reach_expect_q.push_back(typed ? want : res);
    endtask

    // Stop offering, wait for every result, then let trailing edge work finish
    task automatic drain_results();
        in_valid <= 1'b0;
        while (reach_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [VCNT_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        vcount_shadow = v;
        closure_fresh = 1'b0;
        count_writes++;
    endtask

    function automatic grc_pkg::t_in_item rand_item(int n, logic kind, bit noise);
        grc_pkg::t_in_item it;
        it.kind   = kind;
        it.node_a = (noise || n == 0 || $urandom_range(99) < 10) ?
                    NODE_W'($urandom_range(31)) : NODE_W'($urandom_range(n - 1));
        it.node_b = (noise || n == 0 || $urandom_range(99) < 10) ?
                    NODE_W'($urandom_range(31)) : NODE_W'($urandom_range(n - 1));
        return it;
    endfunction

    // Table row builders
    function automatic t_dir_row link_row(int a, int b);
        t_dir_row row;
        row = '0;
        row.item = '{grc_pkg::KIND_EDGE, NODE_W'(a), NODE_W'(b)};
        return row;
    endfunction

    function automatic t_dir_row ask_row(int a, int b);
        t_dir_row row;
        row = '0;
        row.item = '{grc_pkg::KIND_QUERY, NODE_W'(a), NODE_W'(b)};
        return row;
    endfunction

    function automatic t_dir_row ask_chk(int a, int b, logic reach, logic oor);
        t_dir_row row;
        row = ask_row(a, b);
        row.typed = 1'b1;
        row.want  = '{reach, oor};
        return row;
    endfunction

    function automatic t_dir_row count_row(int v);
        t_dir_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = VCNT_W'(v);
        return row;
    endfunction

    initial begin
        int n;
        int left;
        for (int i = 0; i < MAXV; i++)
            reach_mat[i] = MAXV'(1) << i;
        closure_fresh = 1'b0;
        vcount_shadow = VCNT_W'(32);

        dir_tab = '{
            // after reset: identity only
            ask_chk(0, 0, 1'b1, 1'b0),
            ask_chk(0, 31, 1'b0, 1'b0),
            ask_chk(31, 31, 1'b1, 1'b0),
            link_row(0, 31),
            ask_row(31, 0),
            // self edge
            link_row(5, 5),
            ask_row(5, 5),
            // chain of three hops from 0 to 7
            link_row(31, 30),
            link_row(30, 7),
            ask_row(0, 7),
            // shrink count: out-of-range queries and ignored edges
            count_row(8),
            ask_chk(8, 0, 1'b0, 1'b1),
            ask_chk(0, 31, 1'b0, 1'b1),
            link_row(0, 9),
            ask_row(0, 7),              // path found through vertex 31 is kept
            link_row(1, 2),
            link_row(2, 3),
            ask_row(1, 3),
            // zero count: everything out of range
            count_row(0),
            ask_chk(0, 0, 1'b0, 1'b1),
            link_row(0, 0),
            // count above the maximum saturates
            count_row(63),
            link_row(31, 1),
            ask_row(31, 3),
            // single vertex
            count_row(1),
            ask_chk(0, 0, 1'b1, 1'b0),
            ask_chk(1, 0, 1'b0, 1'b1)
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg)
                write_count(dir_tab[k].cfg_val);
            else
                send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
        end

        // Random phases: bursts of edges followed by queries, with some noise
        foreach (phase_counts[ph]) begin
            write_count(phase_counts[ph]);
            if (ph < 6) begin
                tx_idle_pct = 36;
                rx_idle_pct <= 87;
            end else if (ph < 12) begin
                tx_idle_pct = 87;
                rx_idle_pct <= 36;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            if (ph == 4)
                hold_go <= 1'b1;
            n = eff_vertices();
            left = (n > 16) ? 30 : 75;
            while (left > 0) begin
                if ($urandom_range(9) == 0) begin
                    repeat (4) begin
                        send_item(rand_item(n, logic'($urandom_range(1)), 1'b1), 1'b0, '0);
                        left--;
                    end
                end else begin
                    repeat ($urandom_range(5)) begin
                        send_item(rand_item(n, grc_pkg::KIND_EDGE, 1'b0), 1'b0, '0);
                        left--;
                    end
                    repeat ($urandom_range(1, 6)) begin
                        send_item(rand_item(n, grc_pkg::KIND_QUERY, 1'b0), 1'b0, '0);
                        left--;
                    end
                end
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);

        $display("covered %0d beats in, %0d results checked, %0d vertex-count writes",
                 beats_in, results_seen, count_writes);
        $display("idle mixes: sender-heavy, receiver-heavy, none; one long receiver hold");
        if (mismatch_cnt == 0)
            $display("graph_reachability_closure: match");
        else
            $display("graph_reachability_closure: mismatch");
        $finish;
    end

endmodule
